### sv/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property checked at every rising edge, off while reset is held.
`define BOL_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// A condition that must be followed by a consequence in the next cycle.
`define BOL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/bol_pkg.sv
package bol_pkg;

    localparam int POS_W          = 5;
    localparam int CNT_W          = 5;
    localparam int VAL_W          = 32;
    localparam int IN_TDATA_W     = 40;
    localparam int OUT_TDATA_W    = 40;
    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int READ_SPAN      = 32;

    localparam logic [CNT_W-1:0] CAP_RESET = 5'd16;

    // Bit offsets of the result fields in the output tdata.
    localparam int OUT_VAL_LSB    = 0;
    localparam int OUT_STATUS_BIT = 32;
    localparam int OUT_CNT_LSB    = 33;
    localparam int OUT_EMPTY_BIT  = 38;
    localparam int OUT_FULL_BIT   = 39;

    typedef enum logic [1:0] {
        FUNC_APPEND = 2'd0,
        FUNC_INSERT = 2'd1,
        FUNC_REMOVE = 2'd2,
        FUNC_READ   = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_APPEND = 2'd1,
        CELL_INSERT = 2'd2,
        CELL_REMOVE = 2'd3
    } cell_op_t;

    // Broadcast to every cell in the chain.
    typedef struct packed {
        cell_op_t          op;
        logic [POS_W-1:0]  pos;
        logic [CNT_W-1:0]  cnt;
    } cell_ctl_t;

endpackage

### sv/bol_cell.sv
module bol_cell #(
    parameter int DATA_WIDTH = 32,
    parameter int DEPTH      = 16,
    parameter int INDEX      = 0
) (
    input  logic                  clk,
    input  bol_pkg::cell_ctl_t    ctl,
    input  logic [DATA_WIDTH-1:0] word,
    input  logic [DATA_WIDTH-1:0] from_lower,
    input  logic [DATA_WIDTH-1:0] from_upper,
    output logic [DATA_WIDTH-1:0] data
);
    import bol_pkg::*;

    localparam int IDX_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IW       = (IDX_BITS > POS_W) ? IDX_BITS : POS_W;
    localparam logic [IW-1:0] MY_IDX = IW'(INDEX);

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;
    logic [IW-1:0]         pos_x;
    logic [IW-1:0]         cnt_x;

    assign pos_x = IW'(ctl.pos);
    assign cnt_x = IW'(ctl.cnt);

    // Each cell decides on its own, from its place in the row, whether it
    // keeps its word, loads the new word or takes a neighbor's word.
    always_comb
    begin
        data_next = data_reg;
        unique case (ctl.op)
            CELL_APPEND:
            begin
                if (MY_IDX == cnt_x)
                    data_next = word;
            end
            CELL_INSERT:
            begin
                if (MY_IDX == pos_x)
                    data_next = word;
                else if (MY_IDX > pos_x)
                    data_next = from_lower;
            end
            CELL_REMOVE:
            begin
                if (MY_IDX >= pos_x)
                    data_next = from_upper;
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

### sv/bounded_ordered_list_top.sv
// Bounded ordered list of data words, held in a row of shifting cells.
// Input channel s_*: each transfer carries one operation (append, insert at
// a position, remove at a position, read at a position). Output channel m_*:
// exactly one result transfer per operation, in order, with the word read,
// a reject flag, the count after the operation and the empty and full flags.
// The capacity register is written through cfg_we and cfg_wdata; the user
// must write it only while the block is idle, which the block does not
// enforce. Zero rejects everything, values above DEPTH act as DEPTH. A result
// appears on the output register in the cycle after its operation is taken.
// Throughput is one operation per cycle unless the receiver stalls; the cell
// row shifts every entry at once. The output register frees the input side:
// a new operation is taken whenever the output register is empty or its
// result is being taken in the same cycle. When the receiver stalls, the
// result holds steady and the input side stalls with it after one operation.
// Reset clears the count, the output valid and sets the capacity to 16.
// The stored words keep no reset; only words below the count are ever read.
module bounded_ordered_list_top #(
    parameter int DEPTH      = bol_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = bol_pkg::DATA_WIDTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // s_tdata, from bit 0: func[1:0], position[6:2], value_in[38:7], zero pad[39].
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [bol_pkg::IN_TDATA_W-1:0]     s_tdata,
    // m_tdata, from bit 0: value_out[31:0], status[32], count[37:33],
    // empty_res[38], full_res[39].
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [bol_pkg::OUT_TDATA_W-1:0]    m_tdata,
    // Capacity register write.
    input  logic                               cfg_we,
    input  logic [bol_pkg::CNT_W-1:0]          cfg_wdata
);
    import bol_pkg::*;

    // Effective capacity limit; the count field cannot exceed 31.
    localparam int CAP_LIM = (DEPTH < 31) ? DEPTH : 31;

    logic [CNT_W-1:0]       cap_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic [CNT_W-1:0]       cnt_next;
    logic                   out_valid_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;
    logic [OUT_TDATA_W-1:0] out_data_next;

    func_t                  func;
    logic [POS_W-1:0]       pos;
    logic [VAL_W-1:0]       value_in;
    logic [DATA_WIDTH-1:0]  word;

    logic                   accept;
    logic [CNT_W-1:0]       cap_eff;
    logic                   cap_nz;
    logic                   room_ok;
    logic                   op_ok;
    cell_ctl_t              ctl;

    logic [DATA_WIDTH-1:0]  cell_q   [DEPTH];
    logic [DATA_WIDTH-1:0]  read_tab [READ_SPAN];
    logic [DATA_WIDTH-1:0]  rd_word;
    logic [63:0]            rd_wide;
    logic [VAL_W-1:0]       value_out;
    logic [CNT_W-1:0]       cnt_rep;

    assign func     = func_t'(s_tdata[1:0]);
    assign pos      = s_tdata[6:2];
    assign value_in = s_tdata[38:7];
    assign word     = DATA_WIDTH'(value_in);

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign cap_eff = (cap_reg > CNT_W'(CAP_LIM)) ? CNT_W'(CAP_LIM) : cap_reg;
    assign cap_nz  = (cap_eff != '0);
    assign room_ok = cap_nz && (cnt_reg < cap_eff);

    // Decide whether the operation is granted and what the cells must do.
    always_comb
    begin
        op_ok    = 1'b0;
        cnt_next = cnt_reg;
        ctl.op   = CELL_HOLD;
        ctl.pos  = pos;
        ctl.cnt  = cnt_reg;
        unique case (func)
            FUNC_APPEND:
            begin
                op_ok = room_ok;
                if (accept && op_ok)
                begin
                    ctl.op   = CELL_APPEND;
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            FUNC_INSERT:
            begin
                op_ok = room_ok && (pos <= cnt_reg);
                if (accept && op_ok)
                begin
                    ctl.op   = CELL_INSERT;
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            FUNC_REMOVE:
            begin
                op_ok = cap_nz && (pos < cnt_reg);
                if (accept && op_ok)
                begin
                    ctl.op   = CELL_REMOVE;
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            FUNC_READ:
            begin
                op_ok = cap_nz && (pos < cnt_reg);
            end
            default:
            begin
                op_ok = 1'b0;
            end
        endcase
    end

    // The row of cells; each passes its word to both neighbors.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [DATA_WIDTH-1:0] lower;
        logic [DATA_WIDTH-1:0] upper;

        if (i == 0)
        begin : g_first
            assign lower = '0;
        end
        else
        begin : g_mid_lo
            assign lower = cell_q[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign upper = cell_q[i];
        end
        else
        begin : g_mid_hi
            assign upper = cell_q[i+1];
        end

        bol_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .DEPTH      (DEPTH),
            .INDEX      (i)
        ) u_cell (
            .clk        (clk),
            .ctl        (ctl),
            .word       (word),
            .from_lower (lower),
            .from_upper (upper),
            .data       (cell_q[i])
        );
    end

    // Only the first 32 cells can be addressed by a position.
    for (genvar k = 0; k < READ_SPAN; k++)
    begin : g_read
        if (k < DEPTH)
        begin : g_used
            assign read_tab[k] = cell_q[k];
        end
        else
        begin : g_pad
            assign read_tab[k] = '0;
        end
    end

    assign rd_word   = read_tab[pos];
    assign rd_wide   = 64'(rd_word);
    assign value_out = (func == FUNC_READ && op_ok) ? rd_wide[VAL_W-1:0] : '0;
    assign cnt_rep   = cap_nz ? cnt_next : '0;

    always_comb
    begin
        out_data_next                                  = '0;
        out_data_next[OUT_VAL_LSB +: VAL_W]            = value_out;
        out_data_next[OUT_STATUS_BIT]                  = !op_ok;
        out_data_next[OUT_CNT_LSB +: CNT_W]            = cnt_rep;
        out_data_next[OUT_EMPTY_BIT]                   = cap_nz && (cnt_rep == '0);
        out_data_next[OUT_FULL_BIT]                    = cap_nz && (cnt_rep == cap_eff);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= CAP_RESET;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                cap_reg <= cfg_wdata;
            cnt_reg <= cnt_next;
            if (accept)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

### sv/bol_checker.sv
`include "assert_macros.svh"

module bol_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [bol_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import bol_pkg::*;

    logic             took;
    logic             stall;
    logic             res_empty;
    logic             res_full;
    logic             res_reject;
    logic [CNT_W-1:0] res_cnt;
    logic [VAL_W-1:0] res_val;

    assign took       = s_tvalid && s_tready;
    assign stall      = m_tvalid && !m_tready;
    assign res_empty  = m_tvalid && m_tdata[OUT_EMPTY_BIT];
    assign res_full   = m_tvalid && m_tdata[OUT_FULL_BIT];
    assign res_reject = m_tvalid && m_tdata[OUT_STATUS_BIT];
    assign res_cnt    = m_tdata[OUT_CNT_LSB +: CNT_W];
    assign res_val    = m_tdata[OUT_VAL_LSB +: VAL_W];

    // A stalled result stays and keeps its contents.
    `BOL_ASSERT_NEXT(a_hold, clk, rst_n, stall, m_tvalid && $stable(m_tdata), "stall not held")

    // Every accepted operation leaves a result in the output register.
    `BOL_ASSERT_NEXT(a_result, clk, rst_n, took, m_tvalid, "no result after transfer")

    // A list cannot be reported empty and full at once.
    `BOL_ASSERT(a_flags, clk, rst_n, !(res_empty && res_full), "empty and full both set")

    // Empty means a count of zero.
    `BOL_ASSERT(a_empty, clk, rst_n, !res_empty || (res_cnt == '0), "empty with nonzero count")

    // A rejected operation returns no data.
    `BOL_ASSERT(a_reject, clk, rst_n, !res_reject || (res_val == '0), "reject carries data")

endmodule

bind bounded_ordered_list_top bol_checker u_bol_checker (.*);

### verif/bounded_ordered_list_top_tb.sv
module bounded_ordered_list_top_tb;

    import bol_pkg::*;

    localparam int DEPTH            = DEPTH_DEF;
    localparam int CYCLE_LIMIT      = 100000;
    localparam int LONG_HOLD_AT     = 250;
    localparam int LONG_HOLD_CYCLES = 60;
    localparam int MAX_GAP          = 6;
    localparam int DRAIN_CYCLES     = 4;

    localparam logic LIST_OK     = 1'b0;
    localparam logic LIST_REJECT = 1'b1;

    typedef enum logic {
        ROW_OP,
        ROW_CAP
    } row_kind_t;

    typedef struct packed {
        logic [VAL_W-1:0] rd_word;
        logic             rejected;
        logic [CNT_W-1:0] count;
        logic             empty;
        logic             full;
    } list_result_t;

    // For a ROW_CAP row the new capacity travels in pos.
    typedef struct packed {
        row_kind_t        kind;
        func_t            func;
        logic [POS_W-1:0] pos;
        logic [VAL_W-1:0] word;
        logic             typed;
        list_result_t     res;
    } stim_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_we;
    logic [CNT_W-1:0]       cfg_wdata;

    // Shadow copy of the list as the block should hold it.
    logic [VAL_W-1:0] list_words [DEPTH];
    int               list_len;
    logic [CNT_W-1:0] list_cap;

    list_result_t pending_results[$];
    stim_row_t    directed_rows[$];
    int           mismatch_count;
    int           cycle_count;
    bit           sender_steady;

    bounded_ordered_list_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Applies one operation to the shadow list and returns what the block
    // should report for it.
    function automatic list_result_t apply_list_op(func_t f, logic [POS_W-1:0] pos,
                                                   logic [VAL_W-1:0] word);
        list_result_t r;
        int           lim;
        int           p;
        int           shown;
        int           i;
        bit           ok;
        r = '0;
        ok = 1'b0;
        p = int'(pos);
        lim = (int'(list_cap) > DEPTH) ? DEPTH : int'(list_cap);
        if (lim != 0)
        begin
            case (f)
                FUNC_APPEND:
                begin
                    if (list_len < lim)
                    begin
                        list_words[list_len] = word;
                        list_len++;
                        ok = 1'b1;
                    end
                end
                FUNC_INSERT:
                begin
                    if (list_len < lim && p <= list_len)
                    begin
                        for (i = list_len; i > p; i--)
                            list_words[i] = list_words[i-1];
                        list_words[p] = word;
                        list_len++;
                        ok = 1'b1;
                    end
                end
                FUNC_REMOVE:
                begin
                    if (p < list_len)
                    begin
                        for (i = p; i + 1 < list_len; i++)
                            list_words[i] = list_words[i+1];
                        list_len--;
                        ok = 1'b1;
                    end
                end
                default:
                begin
                    if (p < list_len)
                    begin
                        r.rd_word = list_words[p];
                        ok = 1'b1;
                    end
                end
            endcase
        end
        // A zero capacity hides the held entries without dropping them.
        shown = (lim != 0) ? list_len : 0;
        r.rejected = ok ? LIST_OK : LIST_REJECT;
        r.count = CNT_W'(shown);
        r.empty = (lim != 0 && shown == 0);
        r.full = (lim != 0 && shown == lim);
        return r;
    endfunction

    // Offers one operation after a random gap, or at once when the sender is
    // steady, and records its expected result once the transfer has taken place.
    task automatic send_op(stim_row_t row);
        int           gap;
        list_result_t predicted;
        gap = sender_steady ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {1'b0, row.word, row.pos, row.func};
        do
            @(posedge clk);
        while (!s_tready);
        predicted = apply_list_op(row.func, row.pos, row.word);
        pending_results.push_back(row.typed ? row.res : predicted);
    endtask

    // The capacity changes only with the block idle: the sender pauses until
    // every outstanding result has been taken.
    task automatic write_capacity(logic [CNT_W-1:0] cap);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= cap;
        list_cap = cap;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // A run of random operations under one capacity. grow_pct sets the share
    // of appends and inserts; the rest splits between removes and reads.
    task automatic run_phase(logic [CNT_W-1:0] cap, int n_ops, int grow_pct, bit steady);
        stim_row_t row;
        int        k;
        int        roll;
        write_capacity(cap);
        sender_steady = steady;
        for (k = 0; k < n_ops; k++)
        begin
            row = '0;
            row.kind = ROW_OP;
            roll = $urandom_range(0, 99);
            if (roll < grow_pct)
                row.func = $urandom_range(0, 1) ? FUNC_APPEND : FUNC_INSERT;
            else if (roll < grow_pct + (100 - grow_pct) / 2)
                row.func = FUNC_REMOVE;
            else
                row.func = FUNC_READ;
            // Mostly positions that the current length allows, sometimes any.
            if ($urandom_range(0, 6) == 0)
                row.pos = POS_W'($urandom_range(0, 31));
            else if (row.func == FUNC_INSERT)
                row.pos = POS_W'($urandom_range(0, list_len));
            else if (list_len > 0)
                row.pos = POS_W'($urandom_range(0, list_len - 1));
            else
                row.pos = '0;
            case ($urandom_range(0, 7))
                0: row.word = '0;
                1: row.word = '1;
                default: row.word = $urandom();
            endcase
            send_op(row);
        end
    endtask

    // Receiver: a random hold-off after every result, steady stretches, and
    // one long stall that backs the block up into its input.
    initial
    begin : result_sink
        int hold;
        int taken;
        hold = 0;
        taken = 0;
        m_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                taken++;
                if (taken == LONG_HOLD_AT)
                    hold = LONG_HOLD_CYCLES;
                else if ((taken / 64) % 3 == 1)
                    hold = 0;
                else
                    hold = $urandom_range(0, MAX_GAP);
            end
            if (hold > 0)
            begin
                m_tready <= 1'b0;
                hold--;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    // Result checker and run-time limit.
    always @(posedge clk)
    begin
        list_result_t want;
        list_result_t got;
        if (rst_n)
        begin
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT)
            begin
                $display("bounded_ordered_list_top_tb failed");
                $finish;
            end
            if (m_tvalid && m_tready)
            begin
                got.rd_word = m_tdata[OUT_VAL_LSB +: VAL_W];
                got.rejected = m_tdata[OUT_STATUS_BIT];
                got.count = m_tdata[OUT_CNT_LSB +: CNT_W];
                got.empty = m_tdata[OUT_EMPTY_BIT];
                got.full = m_tdata[OUT_FULL_BIT];
                if (pending_results.size() == 0)
                begin
                    $error("result transfer with no operation pending: %h", m_tdata);
                    mismatch_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got.rd_word !== want.rd_word)
                    begin
                        $error("value_out: expected %h, got %h", want.rd_word, got.rd_word);
                        mismatch_count++;
                    end
                    if (got.rejected !== want.rejected)
                    begin
                        $error("status: expected %0d, got %0d", want.rejected, got.rejected);
                        mismatch_count++;
                    end
                    if (got.count !== want.count)
                    begin
                        $error("count: expected %0d, got %0d", want.count, got.count);
                        mismatch_count++;
                    end
                    if (got.empty !== want.empty)
                    begin
                        $error("empty_res: expected %0d, got %0d", want.empty, got.empty);
                        mismatch_count++;
                    end
                    if (got.full !== want.full)
                    begin
                        $error("full_res: expected %0d, got %0d", want.full, got.full);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    initial
    begin
        int p;
        logic [CNT_W-1:0] phase_cap [9];
        int phase_ops [9];
        int phase_grow [9];

        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        mismatch_count = 0;
        cycle_count = 0;
        sender_steady = 1'b0;
        list_len = 0;
        list_cap = CAP_RESET;
        foreach (list_words[i])
            list_words[i] = '0;

        // Directed rows. The results after reset and around the capacity
        // extremes are written out; the rest come from the shadow list.
        directed_rows.push_back('{ROW_OP, FUNC_READ, 5'd0, 32'h0, 1'b1,
                                  '{32'h0, LIST_REJECT, 5'd0, 1'b1, 1'b0}});
        directed_rows.push_back('{ROW_OP, FUNC_REMOVE, 5'd0, 32'h0, 1'b1,
                                  '{32'h0, LIST_REJECT, 5'd0, 1'b1, 1'b0}});
        directed_rows.push_back('{ROW_OP, FUNC_INSERT, 5'd1, 32'h1234, 1'b1,
                                  '{32'h0, LIST_REJECT, 5'd0, 1'b1, 1'b0}});
        directed_rows.push_back('{ROW_OP, FUNC_APPEND, 5'd31, 32'hFFFF_FFFF, 1'b1,
                                  '{32'h0, LIST_OK, 5'd1, 1'b0, 1'b0}});
        directed_rows.push_back('{ROW_OP, FUNC_INSERT, 5'd0, 32'h0, 1'b1,
                                  '{32'h0, LIST_OK, 5'd2, 1'b0, 1'b0}});
        directed_rows.push_back('{ROW_OP, FUNC_READ, 5'd0, 32'h0, 1'b1,
                                  '{32'h0, LIST_OK, 5'd2, 1'b0, 1'b0}});
        directed_rows.push_back('{ROW_OP, FUNC_READ, 5'd1, 32'h0, 1'b1,
                                  '{32'hFFFF_FFFF, LIST_OK, 5'd2, 1'b0, 1'b0}});
        directed_rows.push_back('{ROW_OP, FUNC_READ, 5'd31, 32'h0, 1'b1,
                                  '{32'h0, LIST_REJECT, 5'd2, 1'b0, 1'b0}});
        directed_rows.push_back('{ROW_OP, FUNC_REMOVE, 5'd0, 32'h0, 1'b1,
                                  '{32'h0, LIST_OK, 5'd1, 1'b0, 1'b0}});
        // Zero capacity: everything is rejected and the count reads zero.
        directed_rows.push_back('{ROW_CAP, FUNC_APPEND, 5'd0, 32'h0, 1'b0, '0});
        directed_rows.push_back('{ROW_OP, FUNC_APPEND, 5'd0, 32'h5, 1'b1,
                                  '{32'h0, LIST_REJECT, 5'd0, 1'b0, 1'b0}});
        directed_rows.push_back('{ROW_OP, FUNC_READ, 5'd0, 32'h0, 1'b1,
                                  '{32'h0, LIST_REJECT, 5'd0, 1'b0, 1'b0}});
        // Capacity one: the kept entry shows again and the list is full.
        directed_rows.push_back('{ROW_CAP, FUNC_APPEND, 5'd1, 32'h0, 1'b0, '0});
        directed_rows.push_back('{ROW_OP, FUNC_READ, 5'd0, 32'h0, 1'b1,
                                  '{32'hFFFF_FFFF, LIST_OK, 5'd1, 1'b0, 1'b1}});
        directed_rows.push_back('{ROW_OP, FUNC_APPEND, 5'd0, 32'h7, 1'b1,
                                  '{32'h0, LIST_REJECT, 5'd1, 1'b0, 1'b1}});
        directed_rows.push_back('{ROW_OP, FUNC_INSERT, 5'd0, 32'h7, 1'b1,
                                  '{32'h0, LIST_REJECT, 5'd1, 1'b0, 1'b1}});
        // Largest register value, which saturates at the depth.
        directed_rows.push_back('{ROW_CAP, FUNC_APPEND, 5'd31, 32'h0, 1'b0, '0});
        directed_rows.push_back('{ROW_OP, FUNC_APPEND, 5'd0, 32'hA5A5_A5A5, 1'b0, '0});
        directed_rows.push_back('{ROW_OP, FUNC_INSERT, 5'd2, 32'h5A5A_5A5A, 1'b0, '0});
        directed_rows.push_back('{ROW_OP, FUNC_INSERT, 5'd1, 32'h0F0F_0F0F, 1'b0, '0});
        directed_rows.push_back('{ROW_OP, FUNC_REMOVE, 5'd3, 32'h0, 1'b0, '0});
        directed_rows.push_back('{ROW_OP, FUNC_READ, 5'd2, 32'h0, 1'b0, '0});
        directed_rows.push_back('{ROW_OP, FUNC_REMOVE, 5'd0, 32'h0, 1'b0, '0});
        directed_rows.push_back('{ROW_OP, FUNC_READ, 5'd0, 32'h0, 1'b0, '0});

        // Random phases: fill up, drop the capacity below the count, hide everything,
        // saturate, run single-entry and two-entry lists, and try a random capacity.
        phase_cap = '{5'd16, 5'd5, 5'd0, 5'd31, 5'd1, 5'd16, 5'd16, 5'd2, 5'd16};
        phase_cap[6] = CNT_W'($urandom_range(0, 31));
        phase_ops = '{100, 100, 30, 100, 80, 100, 100, 80, 100};
        phase_grow = '{70, 40, 50, 75, 50, 30, 55, 50, 60};

        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[r])
        begin
            if (directed_rows[r].kind == ROW_CAP)
                write_capacity(directed_rows[r].pos);
            else
                send_op(directed_rows[r]);
        end

        for (p = 0; p < 9; p++)
            run_phase(phase_cap[p], phase_ops[p], phase_grow[p], (p % 3) == 2);

        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            $error("%0d expected results never arrived", pending_results.size());
            mismatch_count++;
        end

        if (mismatch_count == 0)
            $display("bounded_ordered_list_top_tb passed");
        else
            $display("bounded_ordered_list_top_tb failed");
        $finish;
    end

endmodule
